FILE: hw/rtl/mhpq_pkg.sv
// Package for the max-heap priority queue: item types, status and state codes,
// sizing constants and the slot-to-address helper.
// It depends on nothing and is imported by the top level and by the checker.
package mhpq_pkg;

  localparam int HeapDepth = 1024;
  localparam int AddrW     = $clog2(HeapDepth);
  localparam int CountW    = 11;
  localparam int DataW     = 32;

  typedef enum logic [1:0] {
    StatusDone      = 2'd0,
    StatusOverflow  = 2'd1,
    StatusUnderflow = 2'd2
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] removed_value;
    logic [CountW-1:0]       entry_count;
    logic signed [DataW-1:0] top_value;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StUpRead,
    StUpCmp,
    StDnLast,
    StDnRead,
    StDnCmp,
    StFinish
  } state_e;

  // Slots are numbered from one; the store is addressed from zero.
  function automatic logic [AddrW-1:0] slot_addr(input logic [CountW-1:0] slot);
    logic [CountW-1:0] idx;
    idx = slot - CountW'(1);
    return idx[AddrW-1:0];
  endfunction

endpackage

FILE: hw/rtl/max_heap_priority_queue_unit.sv
// Max-heap priority queue: top level with the sift sequencer and result register.
// It depends on mhpq_pkg and instantiates the heap store mhpq_ram.
//
// Each input item is an insert of a signed value or a removal of the maximum, and
// each gives exactly one result item with status, removed value, entry count and
// the maximum left at the root. Items are taken on in_valid_i while in_stall_o is
// low; in_stall_o stays high while an item is being worked on. The one register,
// capacity, is written with cfg_we_i and cfg_data_i; the user must write it only
// while the block is idle, and the block itself does not enforce this. The store,
// with one write and two read ports, serves every level of a sift. An insert
// starts at the new last slot and climbs, moving each smaller parent down, until
// the value is no larger than its parent or it reaches the root; a removal moves
// the last entry to the root and descends, moving the larger child up while it wins.
// The result waits in an output register; while out_stall_i is high it holds,
// and the next item may already be accepted and worked on, finishing only once
// the register is free. Reset empties the heap and sets capacity to 1024; the
// store itself is not cleared; a value read beyond the entry count is unused.
module max_heap_priority_queue_unit
  import mhpq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i
);

  state_e                  state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [CountW-1:0]       capacity_q;
  logic [CountW-1:0]       pos_q, pos_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic signed [DataW-1:0] top_q;
  logic signed [DataW-1:0] removed_q, removed_d;
  status_e                 status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q;
  logic                    out_load;

  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic [AddrW-1:0]        raddr_a, raddr_b;
  logic [DataW-1:0]        rdata_a, rdata_b;

  logic [CountW-1:0]       cap;
  logic [CountW:0]         child;
  logic [CountW:0]         count_ext;
  logic signed [DataW-1:0] big_val;
  logic [CountW-1:0]       big_slot;
  logic                    accept;

  mhpq_ram #(
    .Depth(HeapDepth),
    .Width(DataW)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  assign cap       = (capacity_q > CountW'(HeapDepth)) ? CountW'(HeapDepth) : capacity_q;
  assign child     = {pos_q, 1'b0};
  assign count_ext = {1'b0, count_q};
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    if ((child < count_ext) && ($signed(rdata_b) > $signed(rdata_a))) begin
      big_val  = rdata_b;
      big_slot = child[CountW-1:0] + CountW'(1);
    end else begin
      big_val  = rdata_a;
      big_slot = child[CountW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    val_d     = val_q;
    removed_d = removed_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = slot_addr(pos_q);
    mem_wdata = val_q;
    raddr_a   = '0;
    raddr_b   = '0;
    out_load  = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          removed_d = '0;
          status_d  = StatusDone;
          if (in_item_i.op == OpInsert) begin
            if (count_q < cap) begin
              count_d = count_q + CountW'(1);
              pos_d   = count_q + CountW'(1);
              val_d   = in_item_i.value;
              state_d = StUpRead;
            end else begin
              status_d = StatusOverflow;
              state_d  = StFinish;
            end
          end else begin
            if ((count_q == '0) || (count_q > CountW'(HeapDepth))) begin
              status_d = StatusUnderflow;
              state_d  = StFinish;
            end else begin
              removed_d = top_q;
              count_d   = count_q - CountW'(1);
              raddr_a   = slot_addr(count_q);
              state_d   = StDnLast;
            end
          end
        end
      end
      StUpRead: begin
        if (pos_q == CountW'(1)) begin
          mem_we  = 1'b1;
          state_d = StFinish;
        end else begin
          raddr_a = slot_addr(pos_q >> 1);
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        mem_we = 1'b1;
        if (val_q > $signed(rdata_a)) begin
          mem_wdata = rdata_a;
          pos_d     = pos_q >> 1;
          state_d   = StUpRead;
        end else begin
          state_d = StFinish;
        end
      end
      StDnLast: begin
        val_d   = rdata_a;
        pos_d   = CountW'(1);
        state_d = StDnRead;
      end
      StDnRead: begin
        if (child > count_ext) begin
          mem_we  = 1'b1;
          state_d = StFinish;
        end else begin
          raddr_a = AddrW'(child - (CountW+1)'(1));
          raddr_b = AddrW'(child);
          state_d = StDnCmp;
        end
      end
      StDnCmp: begin
        mem_we = 1'b1;
        if (big_val > val_q) begin
          mem_wdata = big_val;
          pos_d     = big_slot;
          state_d   = StDnRead;
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      capacity_q  <= CountW'(HeapDepth);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    val_q     <= val_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    if (mem_we && (mem_waddr == '0)) begin
      top_q <= mem_wdata;
    end
    if (out_load) begin
      out_item_q.status        <= status_q;
      out_item_q.removed_value <= removed_q;
      out_item_q.entry_count   <= count_q;
      out_item_q.top_value     <= (count_q != '0) ? top_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hw/rtl/mhpq_ram.sv
// Generic store with one write port and two read ports, read data registered.
// It depends on nothing; the heap sequencer instantiates it.
module mhpq_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: hw/rtl/mhpq_checker.sv
// Port-level checker for the max-heap priority queue, bound to the top level.
// It depends on mhpq_pkg and watches only the ports of max_heap_priority_queue_unit.
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result item changed or vanished.");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == StatusUnderflow) |->
      (out_item_o.entry_count == '0) && (out_item_o.removed_value == '0))
    else $error("Underflow reported on a heap that is not empty.");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.entry_count == '0) |-> (out_item_o.top_value == '0))
    else $error("Empty heap reports a non-zero maximum.");

  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == StatusOverflow) |->
      (out_item_o.removed_value == '0))
    else $error("Refused insert reports a removal.");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (.*);
